// File: sv/character_class_tokenizer_unit_macros.svh
// assertion macros for the character class tokenizer
`ifndef CHARACTER_CLASS_TOKENIZER_UNIT_MACROS_SVH
`define CHARACTER_CLASS_TOKENIZER_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CCTOK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CCTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/cctok_pkg.sv
// shared types and constants of the character class tokenizer
`default_nettype none
package cctok_pkg;

	// line capacity and position widths
	localparam int LINE_CAPACITY = 4096;
	localparam int START_W = 12;
	localparam int POS_W = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// token class codes
	localparam logic [2:0] CLS_NUMBER = 3'd0;
	localparam logic [2:0] CLS_OPERATOR = 3'd1;
	localparam logic [2:0] CLS_WORD = 3'd2;
	localparam logic [2:0] CLS_STRING = 3'd3;
	localparam logic [2:0] CLS_UNTERM = 3'd4;

	// scan state, one-hot
	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_NUM = 5'b00010,
		MODE_OP = 5'b00100,
		MODE_WORD = 5'b01000,
		MODE_STR = 5'b10000
	} mode_t;

	// one token as it leaves the block
	typedef struct packed {
		logic [START_W-1:0] start;
		logic [POS_W-1:0] stop;
		logic [2:0] cls;
		logic last;
	} token_t;

	// tokens caused by one item, packed from slot zero
	typedef struct packed {
		logic [1:0] count;
		token_t tok0;
		token_t tok1;
	} step_t;

	// queue status seen by the front end
	typedef struct packed {
		logic room2;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

endpackage
`default_nettype wire

// File: sv/character_class_tokenizer_unit.sv
// Character class tokenizer, top level. Takes one text byte per item and
// returns tokens (start, end one past the last byte, class) for digit,
// symbol, word and quoted-string runs; a string still open at end of line
// comes out as an unterminated string. An item is taken every cycle while
// the input does not stall: it is registered, classified in the next cycle and
// its zero, one or two tokens enter a four-entry result queue, so a token
// passes the input register and the queue storage before it is offered.
// Tokens leave one per cycle while out_ready is high, so the two tokens of an
// item leave one after the other; input stalls only when the queue has
// fewer than two free entries. Positions saturate at the line capacity of 4096.
`default_nettype none
`include "character_class_tokenizer_unit_macros.svh"
module character_class_tokenizer_unit import cctok_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] text_byte,
	input wire logic end_of_line,
	output logic out_valid,
	input wire logic out_ready,
	output logic [START_W-1:0] token_start,
	output logic [POS_W-1:0] token_end,
	output logic [2:0] token_class,
	output logic last_of_run
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic eol_s1;
	mode_t mode_q, mode_next;
	logic [START_W-1:0] start_q, start_next;
	logic [POS_W-1:0] pos_q, pos_next;
	logic advance_s1;
	step_t step, push;
	queue_stat_t qstat;
	token_t head;

	// the held item moves on when the queue can take two tokens
	assign advance_s1 = valid_s1 && qstat.room2;
	assign in_ready = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eol_s1 <= end_of_line;
		end
	end

	// classification of the held item
	cctok_classify u_classify (
		.text_byte(byte_s1),
		.end_of_line(eol_s1),
		.mode(mode_q),
		.open_start(start_q),
		.pos(pos_q),
		.step(step),
		.mode_next(mode_next),
		.start_next(start_next),
		.pos_next(pos_next)
	);

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			start_q <= '0;
			pos_q <= '0;
		end else if (advance_s1) begin
			mode_q <= mode_next;
			start_q <= start_next;
			pos_q <= pos_next;
		end
	end

	// tokens go to the queue only when the item moves on
	always_comb begin
		push = step;
		if (!advance_s1)
			push.count = 2'd0;
	end

	cctok_result_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.stat(qstat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign token_start = head.start;
	assign token_end = head.stop;
	assign token_class = head.cls;
	assign last_of_run = head.last;

	// checks
	`CCTOK_ASSERT_ALWAYS(a_queue_room, !advance_s1 || qstat.count <= QCNT_W'(QUEUE_DEPTH - 2), "result queue overflow")
	`CCTOK_ASSERT_ALWAYS(a_pos_sat, pos_q <= POS_W'(LINE_CAPACITY), "position past capacity")
	`CCTOK_ASSERT_NEXT(a_eol_reset, advance_s1 && eol_s1, pos_q == '0 && mode_q == MODE_IDLE, "line end did not clear state")

endmodule
`default_nettype wire

// File: sv/cctok_classify.sv
// byte classification and next-state logic for one item
`default_nettype none
module cctok_classify import cctok_pkg::*; (
	input wire logic [7:0] text_byte,
	input wire logic end_of_line,
	input wire mode_t mode,
	input wire logic [START_W-1:0] open_start,
	input wire logic [POS_W-1:0] pos,
	output step_t step,
	output mode_t mode_next,
	output logic [START_W-1:0] start_next,
	output logic [POS_W-1:0] pos_next
);

	localparam logic [POS_W-1:0] CAP = POS_W'(LINE_CAPACITY);
	localparam logic [POS_W-1:0] CAP_M1 = POS_W'(LINE_CAPACITY - 1);

	// mode a byte of a run belongs to, idle for bytes of no class
	function automatic mode_t byte_mode(input logic [7:0] b);
		mode_t m;
		m = MODE_IDLE;
		if (b >= 8'h30 && b <= 8'h39)
			m = MODE_NUM;
		else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
			m = MODE_WORD;
		else if ((b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
				(b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E))
			m = MODE_OP;
		return m;
	endfunction

	// token class of an open run
	function automatic logic [2:0] mode_class(input mode_t m);
		logic [2:0] c;
		case (m)
			MODE_NUM: c = CLS_NUMBER;
			MODE_OP: c = CLS_OPERATOR;
			MODE_WORD: c = CLS_WORD;
			default: c = CLS_STRING;
		endcase
		return c;
	endfunction

	logic [START_W-1:0] here;
	logic [POS_W-1:0] after;
	logic is_open, is_quote, is_space;
	mode_t cls_mode, mode_mid;
	logic [START_W-1:0] start_mid;
	logic emit0, emit1;
	token_t r0, r1;

	// clamped positions
	assign here = (pos >= CAP) ? START_W'(LINE_CAPACITY - 1) : pos[START_W-1:0];
	assign after = (pos >= CAP_M1) ? CAP : pos + POS_W'(1);
	assign is_open = (mode == MODE_NUM) || (mode == MODE_OP) || (mode == MODE_WORD);
	assign is_quote = (text_byte == 8'h22);
	assign is_space = (text_byte == 8'h20) || (text_byte == 8'h0A) || (text_byte == 8'h09);
	assign cls_mode = byte_mode(text_byte);

	// byte handling: may close the open token and open a new one
	always_comb begin
		emit0 = 1'b0;
		r0 = '{start: open_start, stop: pos, cls: mode_class(mode), last: 1'b0};
		mode_mid = mode;
		start_mid = open_start;
		if (mode == MODE_STR) begin
			if (is_quote) begin
				emit0 = 1'b1;
				r0.stop = after;
				r0.cls = CLS_STRING;
				mode_mid = MODE_IDLE;
			end
		end else if (is_space) begin
			if (is_open) begin
				emit0 = 1'b1;
				mode_mid = MODE_IDLE;
			end
		end else if (is_quote) begin
			emit0 = is_open;
			mode_mid = MODE_STR;
			start_mid = here;
		end else if (cls_mode != MODE_IDLE && cls_mode != mode) begin
			emit0 = is_open;
			mode_mid = cls_mode;
			start_mid = here;
		end
	end

	// end of line: flush whatever is still open
	always_comb begin
		emit1 = 1'b0;
		r1 = '{start: start_mid, stop: after, cls: mode_class(mode_mid), last: 1'b1};
		mode_next = mode_mid;
		start_next = start_mid;
		pos_next = after;
		if (end_of_line) begin
			emit1 = (mode_mid != MODE_IDLE);
			if (mode_mid == MODE_STR)
				r1.cls = CLS_UNTERM;
			mode_next = MODE_IDLE;
			start_next = '0;
			pos_next = '0;
		end
	end

	// pack tokens from slot zero, last mark on the final one
	always_comb begin
		step.count = {1'b0, emit0} + {1'b0, emit1};
		step.tok0 = emit0 ? r0 : r1;
		step.tok0.last = !(emit0 && emit1);
		step.tok1 = r1;
	end

endmodule
`default_nettype wire

// File: sv/cctok_result_queue.sv
// small result queue taking up to two tokens a cycle, giving one while out_ready is high
`default_nettype none
module cctok_result_queue import cctok_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire step_t push,
	output queue_stat_t stat,
	output logic out_valid,
	input wire logic out_ready,
	output token_t head
);

	token_t mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign head = mem[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.room2 = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	// token storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_ptr_q] <= push.tok0;
		if (push.count == 2'd2)
			mem[wr_ptr_q + QPTR_W'(1)] <= push.tok1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule
`default_nettype wire
